FILE: rtl/ill_pkg.sv
// Shared types and constants for the indexed linked list engine.
// Used by ill_datapath, ill_controller and indexed_linked_list_engine.
package ill_pkg;

   localparam int CAPACITY      = 64;
   localparam int VALUE_BITS    = 32;
   localparam int SLOT_BITS     = $clog2(CAPACITY);
   localparam int LINK_BITS     = $clog2(CAPACITY + 1);
   localparam int CMD_BITS      = 3;
   localparam int POS_BITS      = 7;
   localparam int POS2_BITS     = 6;
   localparam int FPOS_BITS     = 6;
   localparam int LEN_BITS      = 7;
   localparam int CMP_BITS      = LINK_BITS + 2;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 48;

   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(CAPACITY);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_DELETE  = 3'd1,
      CMD_GET     = 3'd2,
      CMD_SET     = 3'd3,
      CMD_FIND    = 3'd4,
      CMD_SWAP    = 3'd5,
      CMD_REVERSE = 3'd6,
      CMD_CLEAR   = 3'd7
   } cmd_type;

   typedef enum logic [4:0] {
      U_NOP, U_LOAD, U_INS_RDF, U_INS_NF, U_LOC_A, U_LOC_B, U_WALK_FIRST, U_WALK,
      U_RD_CUR, U_LATCH_P, U_INS_W1, U_INS_W2, U_DEL_LATCH, U_DEL_W1, U_DEL_W2,
      U_GET_DONE, U_SET, U_FIND_START, U_FIND_ADV, U_FIND_HIT, U_SAVE_A,
      U_SW_LATCH_B, U_SW_WB, U_SW_WA, U_REV_START, U_REV_W, U_REV_END, U_CLEAR,
      U_PUSH
   } uop_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_LOC, ST_WALK0, ST_WALK, ST_LOC_DONE,
      ST_INS_F, ST_INS_P, ST_INS_P2, ST_INS_W1, ST_INS_W2,
      ST_DEL_R, ST_DEL_L, ST_DEL_W1, ST_DEL_W2, ST_GET_R, ST_GET_L, ST_SET_W,
      ST_FIND_CHK, ST_FIND_CMP, ST_SW_A, ST_SW_RB, ST_SW_RA, ST_SW_WB, ST_SW_WA,
      ST_REV_CHK, ST_REV_W, ST_REV_END, ST_DONE
   } state_type;

   typedef struct packed {
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type op;
      logic    pos_le_cnt;
      logic    pos_lt_cnt;
      logic    pos2_lt_cnt;
      logic    full;
      logic    append;
      logic    steps_zero;
      logic    link_null;
      logic    cur_null;
      logic    k_lt_cnt;
      logic    match;
      logic    more;
      logic    out_free;
   } dp_status_type;

endpackage

FILE: rtl/ill_datapath.sv
// Datapath of the list engine: node store, link stores, list registers, result register.
// Carries out one micro-operation per cycle from ill_controller; depends on ill_pkg.
module ill_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ill_pkg::dp_cmd_type                 cmd,
   output ill_pkg::dp_status_type              status,
   input  logic [ill_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ill_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import ill_pkg::*;

   // stores
   logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
   logic [LINK_BITS-1:0]  next_mem [CAPACITY];
   logic [LINK_BITS-1:0]  prev_mem [CAPACITY];
   logic [CAPACITY-1:0]   nvalid_ff, pvalid_ff;

   logic [LINK_BITS-1:0]  next_raw, prev_raw, next_q, prev_q, link;
   logic [VALUE_BITS-1:0] val_q;
   logic [SLOT_BITS-1:0]  rd_addr, rd_addr_q;
   logic                  nvalid_q, pvalid_q;

   logic                  nw_en, pw_en, vw_en, clr;
   logic [SLOT_BITS-1:0]  nw_addr, pw_addr, vw_addr;
   logic [LINK_BITS-1:0]  nw_data, pw_data;
   logic [VALUE_BITS-1:0] vw_data;

   // request and scratch registers
   cmd_type               op_ff;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS2_BITS-1:0]  pos2_ff, pos2_in;
   logic [VALUE_BITS-1:0] val_ff, val_in, tmp_ff, tmp_in;
   cmd_type               op_in;
   logic [LINK_BITS-1:0]  cur_ff, cur_in, aux_ff, aux_in, idx_ff, idx_in, nf_ff, nf_in;
   logic [LINK_BITS-1:0]  steps_ff, steps_in, k_ff, k_in;
   logic                  dir_ff, dir_in;

   // list registers
   logic [LINK_BITS-1:0]  head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [LEN_BITS-1:0]   count_ff, count_in;

   // result and output stage
   logic                  ok_ff, ok_in;
   logic [VALUE_BITS-1:0] rd_ff, rd_in;
   logic [FPOS_BITS-1:0]  fpos_ff, fpos_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;

   logic [CMP_BITS-1:0]   sel_pos, cnt_x, half;
   logic                  from_head;

   assign next_q = nvalid_q ? next_raw :
                   ((rd_addr_q == SLOT_BITS'(CAPACITY - 1)) ? NIL
                                                            : LINK_BITS'(rd_addr_q) + 1'b1);
   assign prev_q = pvalid_q ? prev_raw : NIL;
   assign link   = dir_ff ? prev_q : next_q;

   assign cnt_x     = CMP_BITS'(count_ff);
   assign half      = (cnt_x + 1'b1) >> 1;
   assign sel_pos   = (cmd.uop == U_LOC_B) ? CMP_BITS'(pos2_ff) : CMP_BITS'(pos_ff);
   assign from_head = sel_pos <= half;

   always_comb begin
      status.op          = op_ff;
      status.pos_le_cnt  = CMP_BITS'(pos_ff) <= cnt_x;
      status.pos_lt_cnt  = CMP_BITS'(pos_ff) < cnt_x;
      status.pos2_lt_cnt = CMP_BITS'(pos2_ff) < cnt_x;
      status.full        = (cnt_x >= CMP_BITS'(CAPACITY)) || (free_ff == NIL);
      status.append      = CMP_BITS'(pos_ff) == cnt_x;
      status.steps_zero  = steps_ff == '0;
      status.link_null   = link == NIL;
      status.cur_null    = cur_ff == NIL;
      status.k_lt_cnt    = CMP_BITS'(k_ff) < cnt_x;
      status.match       = val_q == val_ff;
      status.more        = (CMP_BITS'(k_ff) + 1'b1 < cnt_x) && (next_q != NIL);
      status.out_free    = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      rd_addr = cur_ff[SLOT_BITS-1:0];
      nw_en = 1'b0; nw_addr = cur_ff[SLOT_BITS-1:0]; nw_data = NIL;
      pw_en = 1'b0; pw_addr = cur_ff[SLOT_BITS-1:0]; pw_data = NIL;
      vw_en = 1'b0; vw_addr = cur_ff[SLOT_BITS-1:0]; vw_data = val_ff;
      clr   = 1'b0;
      op_in = op_ff; pos_in = pos_ff; pos2_in = pos2_ff; val_in = val_ff; tmp_in = tmp_ff;
      cur_in = cur_ff; aux_in = aux_ff; idx_in = idx_ff; nf_in = nf_ff;
      steps_in = steps_ff; k_in = k_ff; dir_in = dir_ff;
      head_in = head_ff; tail_in = tail_ff; free_in = free_ff; count_in = count_ff;
      ok_in = ok_ff; rd_in = rd_ff; fpos_in = fpos_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;

      unique case (cmd.uop)
         U_NOP: ;
         U_LOAD: begin
            op_in   = cmd_type'(req_tdata[2:0]);
            pos_in  = req_tdata[9:3];
            pos2_in = req_tdata[15:10];
            val_in  = req_tdata[47:16];
            ok_in   = 1'b0;
            rd_in   = '0;
            fpos_in = '0;
         end
         U_INS_RDF: begin
            rd_addr = free_ff[SLOT_BITS-1:0];
            idx_in  = free_ff;
         end
         U_INS_NF: nf_in = next_q;
         U_LOC_A, U_LOC_B: begin
            dir_in = !from_head;
            if (from_head) begin
               cur_in   = head_ff;
               steps_in = LINK_BITS'(sel_pos);
            end else begin
               cur_in   = tail_ff;
               steps_in = LINK_BITS'(cnt_x - 1'b1 - sel_pos);
            end
         end
         U_WALK_FIRST: begin
            rd_addr  = cur_ff[SLOT_BITS-1:0];
            steps_in = steps_ff - 1'b1;
         end
         U_WALK: begin
            cur_in  = link;
            rd_addr = link[SLOT_BITS-1:0];
            if (steps_ff != '0) begin
               steps_in = steps_ff - 1'b1;
            end
         end
         U_RD_CUR: rd_addr = cur_ff[SLOT_BITS-1:0];
         U_LATCH_P: aux_in = prev_q;
         U_INS_W1: begin
            vw_en   = 1'b1;
            vw_addr = idx_ff[SLOT_BITS-1:0];
            nw_en   = 1'b1;
            nw_addr = idx_ff[SLOT_BITS-1:0];
            nw_data = status.append ? NIL : cur_ff;
            pw_en   = 1'b1;
            pw_addr = idx_ff[SLOT_BITS-1:0];
            pw_data = status.append ? tail_ff : aux_ff;
         end
         U_INS_W2: begin
            nw_data = idx_ff;
            if (status.append) begin
               if (tail_ff != NIL) begin
                  nw_en   = 1'b1;
                  nw_addr = tail_ff[SLOT_BITS-1:0];
               end else begin
                  head_in = idx_ff;
               end
               tail_in = idx_ff;
            end else begin
               pw_en   = 1'b1;
               pw_data = idx_ff;
               if (aux_ff != NIL) begin
                  nw_en   = 1'b1;
                  nw_addr = aux_ff[SLOT_BITS-1:0];
               end else begin
                  head_in = idx_ff;
               end
            end
            free_in  = nf_ff;
            count_in = count_ff + 1'b1;
            ok_in    = 1'b1;
         end
         U_DEL_LATCH: begin
            tmp_in = val_q;
            aux_in = prev_q;
            nf_in  = next_q;
         end
         U_DEL_W1: begin
            // unlink: prev -> next and next -> prev, or move the ends
            if (aux_ff != NIL) begin
               nw_en   = 1'b1;
               nw_addr = aux_ff[SLOT_BITS-1:0];
               nw_data = nf_ff;
            end else begin
               head_in = nf_ff;
            end
            if (nf_ff != NIL) begin
               pw_en   = 1'b1;
               pw_addr = nf_ff[SLOT_BITS-1:0];
               pw_data = aux_ff;
            end else begin
               tail_in = aux_ff;
            end
         end
         U_DEL_W2: begin
            nw_en    = 1'b1;
            nw_data  = free_ff;
            pw_en    = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - 1'b1;
            ok_in    = 1'b1;
            rd_in    = tmp_ff;
         end
         U_GET_DONE: begin
            ok_in = 1'b1;
            rd_in = val_q;
         end
         U_SET: begin
            vw_en = 1'b1;
            ok_in = 1'b1;
         end
         U_FIND_START, U_REV_START: begin
            cur_in = head_ff;
            k_in   = '0;
         end
         U_FIND_ADV: begin
            cur_in  = next_q;
            k_in    = k_ff + 1'b1;
            rd_addr = next_q[SLOT_BITS-1:0];
         end
         U_FIND_HIT: begin
            ok_in   = 1'b1;
            fpos_in = k_ff[FPOS_BITS-1:0];
         end
         U_SAVE_A: idx_in = cur_ff;
         U_SW_LATCH_B: begin
            tmp_in  = val_q;
            rd_addr = idx_ff[SLOT_BITS-1:0];
         end
         U_SW_WB: begin
            vw_en   = 1'b1;
            vw_data = val_q;
         end
         U_SW_WA: begin
            vw_en   = 1'b1;
            vw_addr = idx_ff[SLOT_BITS-1:0];
            vw_data = tmp_ff;
            ok_in   = 1'b1;
         end
         U_REV_W: begin
            nw_en   = 1'b1;
            nw_data = prev_q;
            pw_en   = 1'b1;
            pw_data = next_q;
            cur_in  = next_q;
            k_in    = k_ff + 1'b1;
            rd_addr = next_q[SLOT_BITS-1:0];
         end
         U_REV_END: begin
            head_in = tail_ff;
            tail_in = head_ff;
            ok_in   = 1'b1;
         end
         U_CLEAR: begin
            clr      = 1'b1;
            head_in  = NIL;
            tail_in  = NIL;
            free_in  = '0;
            count_in = '0;
            ok_in    = 1'b1;
         end
         U_PUSH: begin
            out_valid_in = 1'b1;
            out_data_in  = RSP_DATA_BITS'({count_ff, fpos_ff, rd_ff, ok_ff});
         end
         default: ;
      endcase
   end

   // store access: one write and one registered read per array and cycle
   always_ff @(posedge clock) begin
      if (nw_en) begin
         next_mem[nw_addr] <= nw_data;
      end
      if (pw_en) begin
         prev_mem[pw_addr] <= pw_data;
      end
      if (vw_en) begin
         val_mem[vw_addr] <= vw_data;
      end
      next_raw  <= next_mem[rd_addr];
      prev_raw  <= prev_mem[rd_addr];
      val_q     <= val_mem[rd_addr];
      nvalid_q  <= nvalid_ff[rd_addr];
      pvalid_q  <= pvalid_ff[rd_addr];
      rd_addr_q <= rd_addr;
   end

   // entries without a valid bit read as the free list set up at reset
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         nvalid_ff <= '0;
         pvalid_ff <= '0;
      end else begin
         if (nw_en) begin
            nvalid_ff[nw_addr] <= 1'b1;
         end
         if (pw_en) begin
            pvalid_ff[pw_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         tail_ff      <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      pos2_ff     <= pos2_in;
      val_ff      <= val_in;
      tmp_ff      <= tmp_in;
      cur_ff      <= cur_in;
      aux_ff      <= aux_in;
      idx_ff      <= idx_in;
      nf_ff       <= nf_in;
      steps_ff    <= steps_in;
      k_ff        <= k_in;
      dir_ff      <= dir_in;
      ok_ff       <= ok_in;
      rd_ff       <= rd_in;
      fpos_ff     <= fpos_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(count_ff) <= CMP_BITS'(CAPACITY))
      else $error("element count above capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == U_CLEAR |=> (count_ff == '0) && (head_ff == NIL) && (free_ff == '0))
      else $error("clear left list state behind");

   a_free_empty_full: assert property (@(posedge clock) disable iff (reset)
      free_ff == NIL |-> CMP_BITS'(count_ff) == CMP_BITS'(CAPACITY))
      else $error("free list empty while list not full");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == U_PUSH |-> (!out_valid_ff || rsp_tready))
      else $error("result pushed over a pending response");

endmodule

FILE: rtl/ill_controller.sv
// Sequencer of the list engine: steps each request through its micro-operations.
// Drives ill_datapath through a command struct; depends on ill_pkg.
module ill_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ill_pkg::dp_status_type status,
   output ill_pkg::dp_cmd_type    cmd
);
   import ill_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      loc_b_ff, loc_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      loc_b_ff <= loc_b_in;
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      loc_b_in   = loc_b_ff;
      cmd.uop    = U_NOP;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.uop  = U_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            loc_b_in = 1'b0;
            state_in = ST_DONE;
            unique case (status.op)
               CMD_INSERT: begin
                  if (status.pos_le_cnt && !status.full) begin
                     cmd.uop  = U_INS_RDF;
                     state_in = ST_INS_F;
                  end
               end
               CMD_DELETE: begin
                  if (status.pos_lt_cnt) begin
                     ret_in   = ST_DEL_R;
                     state_in = ST_LOC;
                  end
               end
               CMD_GET: begin
                  if (status.pos_lt_cnt) begin
                     ret_in   = ST_GET_R;
                     state_in = ST_LOC;
                  end
               end
               CMD_SET: begin
                  if (status.pos_lt_cnt) begin
                     ret_in   = ST_SET_W;
                     state_in = ST_LOC;
                  end
               end
               CMD_FIND: begin
                  cmd.uop  = U_FIND_START;
                  state_in = ST_FIND_CHK;
               end
               CMD_SWAP: begin
                  if (status.pos_lt_cnt && status.pos2_lt_cnt) begin
                     ret_in   = ST_SW_A;
                     state_in = ST_LOC;
                  end
               end
               CMD_REVERSE: begin
                  cmd.uop  = U_REV_START;
                  state_in = ST_REV_CHK;
               end
               CMD_CLEAR: cmd.uop = U_CLEAR;
               default: ;
            endcase
         end
         // position walk, shared by delete, get, set, swap and non-appending insert
         ST_LOC: begin
            cmd.uop  = loc_b_ff ? U_LOC_B : U_LOC_A;
            state_in = ST_WALK0;
         end
         ST_WALK0: begin
            if (status.steps_zero) begin
               state_in = ST_LOC_DONE;
            end else begin
               cmd.uop  = U_WALK_FIRST;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.uop = U_WALK;
            if (status.link_null) begin
               state_in = ST_DONE;
            end else if (status.steps_zero) begin
               state_in = ST_LOC_DONE;
            end
         end
         ST_LOC_DONE: state_in = status.cur_null ? ST_DONE : ret_ff;
         ST_INS_F: begin
            cmd.uop = U_INS_NF;
            if (status.append) begin
               state_in = ST_INS_W1;
            end else begin
               ret_in   = ST_INS_P;
               state_in = ST_LOC;
            end
         end
         ST_INS_P: begin
            cmd.uop  = U_RD_CUR;
            state_in = ST_INS_P2;
         end
         ST_INS_P2: begin
            cmd.uop  = U_LATCH_P;
            state_in = ST_INS_W1;
         end
         ST_INS_W1: begin
            cmd.uop  = U_INS_W1;
            state_in = ST_INS_W2;
         end
         ST_INS_W2: begin
            cmd.uop  = U_INS_W2;
            state_in = ST_DONE;
         end
         ST_DEL_R: begin
            cmd.uop  = U_RD_CUR;
            state_in = ST_DEL_L;
         end
         ST_DEL_L: begin
            cmd.uop  = U_DEL_LATCH;
            state_in = ST_DEL_W1;
         end
         ST_DEL_W1: begin
            cmd.uop  = U_DEL_W1;
            state_in = ST_DEL_W2;
         end
         ST_DEL_W2: begin
            cmd.uop  = U_DEL_W2;
            state_in = ST_DONE;
         end
         ST_GET_R: begin
            cmd.uop  = U_RD_CUR;
            state_in = ST_GET_L;
         end
         ST_GET_L: begin
            cmd.uop  = U_GET_DONE;
            state_in = ST_DONE;
         end
         ST_SET_W: begin
            cmd.uop  = U_SET;
            state_in = ST_DONE;
         end
         ST_FIND_CHK: begin
            if (status.cur_null || !status.k_lt_cnt) begin
               state_in = ST_DONE;
            end else begin
               cmd.uop  = U_RD_CUR;
               state_in = ST_FIND_CMP;
            end
         end
         ST_FIND_CMP: begin
            if (status.match) begin
               cmd.uop  = U_FIND_HIT;
               state_in = ST_DONE;
            end else if (status.more) begin
               cmd.uop = U_FIND_ADV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SW_A: begin
            cmd.uop  = U_SAVE_A;
            loc_b_in = 1'b1;
            ret_in   = ST_SW_RB;
            state_in = ST_LOC;
         end
         ST_SW_RB: begin
            cmd.uop  = U_RD_CUR;
            state_in = ST_SW_RA;
         end
         ST_SW_RA: begin
            cmd.uop  = U_SW_LATCH_B;
            state_in = ST_SW_WB;
         end
         ST_SW_WB: begin
            cmd.uop  = U_SW_WB;
            state_in = ST_SW_WA;
         end
         ST_SW_WA: begin
            cmd.uop  = U_SW_WA;
            state_in = ST_DONE;
         end
         ST_REV_CHK: begin
            if (status.cur_null || !status.k_lt_cnt) begin
               state_in = ST_REV_END;
            end else begin
               cmd.uop  = U_RD_CUR;
               state_in = ST_REV_W;
            end
         end
         ST_REV_W: begin
            cmd.uop = U_REV_W;
            if (!status.more) begin
               state_in = ST_REV_END;
            end
         end
         ST_REV_END: begin
            cmd.uop  = U_REV_END;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.uop  = U_PUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == U_LOAD |-> state_ff == ST_IDLE && req_tvalid)
      else $error("request loaded outside idle");

   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == U_LOAD |=> state_ff == ST_DISPATCH)
      else $error("loaded request not dispatched");

   a_push_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == U_PUSH |=> state_ff == ST_IDLE)
      else $error("result push did not free the engine");

endmodule

FILE: rtl/indexed_linked_list_engine.sv
// Doubly linked list engine over a 64-slot node store with a free list.
// A rejected request or a clear goes straight to the response; an append writes
// without a walk, and the other positional commands walk the list first; a walk starts at the
// nearer end (at most 32 links), and swap walks twice. Find and reverse visit the
// elements in list order. One request at a time; the next can be accepted in the same
// cycle as the registered response is first presented. Sync reset empties the list.
module indexed_linked_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command[2:0], position[9:3], other_position[15:10], value[47:16]
   input  logic [ill_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // ok[0], read_value[32:1], found_position[38:33], length[45:39], zero above
   output logic [ill_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import ill_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ill_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   ill_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/indexed_linked_list_engine_checker.sv
// Checker for the indexed linked list engine: watches both streams, keeps its
// own list model, and compares every response. Depends on ill_pkg.
module indexed_linked_list_engine_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ill_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ill_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 response_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ill_pkg::*;

   // packed from the top down: ok ends up in bit 0
   typedef struct packed {
      logic [6:0]  length;
      logic [5:0]  found_position;
      logic [31:0] read_value;
      logic        ok;
   } list_result;

   // list model: ordered values, mirrors the linked store by position
   logic [31:0] list_values[$];
   list_result  expected_results[$];

   function automatic list_result apply_command(logic [47:0] request);
      cmd_type     op;
      logic [6:0]  pos;
      logic [5:0]  pos2;
      logic [31:0] val;
      logic [31:0] held;
      list_result  r;
      op   = cmd_type'(request[2:0]);
      pos  = request[9:3];
      pos2 = request[15:10];
      val  = request[47:16];
      r    = '0;
      case (op)
         CMD_INSERT: if (list_values.size() < CAPACITY && pos <= list_values.size()) begin
            list_values.insert(pos, val);
            r.ok = 1;
         end
         CMD_DELETE: if (pos < list_values.size()) begin
            r.read_value = list_values[pos];
            list_values.delete(pos);
            r.ok = 1;
         end
         CMD_GET: if (pos < list_values.size()) begin
            r.read_value = list_values[pos];
            r.ok = 1;
         end
         CMD_SET: if (pos < list_values.size()) begin
            list_values[pos] = val;
            r.ok = 1;
         end
         CMD_FIND: begin
            for (int k = 0; k < list_values.size(); k++)
               if (!r.ok && list_values[k] == val) begin
                  r.ok = 1;
                  r.found_position = 6'(k);
               end
         end
         CMD_SWAP: if (pos < list_values.size() && pos2 < list_values.size()) begin
            held = list_values[pos];
            list_values[pos] = list_values[pos2];
            list_values[pos2] = held;
            r.ok = 1;
         end
         CMD_REVERSE: begin
            list_values.reverse();
            r.ok = 1;
         end
         default: begin
            list_values.delete();
            r.ok = 1;
         end
      endcase
      r.length = 7'(list_values.size());
      return r;
   endfunction

   always @(posedge clock) begin
      list_result seen;
      list_result want;
      if (reset) begin
         list_values.delete();
         expected_results.delete();
         error_count <= 0;
         response_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(), apply_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[45:0];
            response_count <= response_count + 1;
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: unexpected response %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (seen !== want || rsp_tdata[47:46] !== 2'b00) begin
                  if (error_count < 10)
                     $display("ERROR: ok %b/%b value %h/%h fpos %0d/%0d len %0d/%0d (exp/got)",
                        want.ok, seen.ok, want.read_value, seen.read_value,
                        want.found_position, seen.found_position, want.length, seen.length);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end
endmodule

FILE: tb/indexed_linked_list_engine_test.sv
// Testbench top for indexed_linked_list_engine: drives list commands with bursty
// traffic and a stalling receiver. Depends on ill_pkg and the checker module.
module indexed_linked_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ill_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   int          error_count, pending_count, response_count;
   int          hold_cycles = 0;
   logic        pressure_go = 0;
   logic        hold_done = 0;
   int          request_count = 0;
   int          model_length = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   indexed_linked_list_engine DUT (.*);

   indexed_linked_list_engine_checker checker_inst (.*);

   // receiver: long hold-off counted here, else ready or an LFSR stall pattern
   logic [7:0] stall_pattern = 8'b1011_0011;
   always @(posedge clock) begin
      if (pressure_go && !hold_done) begin
         hold_done   <= 1;
         hold_cycles <= 600;
         rsp_tready  <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         stall_pattern <= {stall_pattern[6:0], stall_pattern[7] ^ stall_pattern[5]};
         rsp_tready <= (request_count % 300 < 100) ? 1'b1 : stall_pattern[0] | stall_pattern[3];
      end
   end

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(cmd_type op, logic [6:0] pos, logic [5:0] pos2,
                               logic [31:0] val);
      req_tdata  <= {val, pos2, pos, op};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
      // rough length tracking to bias random positions
      if (op == CMD_INSERT && pos <= model_length && model_length < CAPACITY) model_length++;
      if (op == CMD_DELETE && pos < model_length) model_length--;
      if (op == CMD_CLEAR) model_length = 0;
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   logic [6:0] pos;
   cmd_type    op;
   int         burst;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty-list edge cases, then fill, then every op at the ends
      send_request(CMD_DELETE, 0, 0, 0);
      send_request(CMD_GET, 0, 0, 0);
      send_request(CMD_FIND, 0, 0, 0);
      send_request(CMD_REVERSE, 0, 0, 0);
      send_request(CMD_SWAP, 0, 0, 0);
      send_request(CMD_INSERT, 1, 0, 5);
      for (int k = 0; k < CAPACITY; k++)
         send_request(CMD_INSERT, 7'($urandom_range(0, k)), 0,
                      k == 3 ? 32'h8000_0000 : $urandom());
      send_request(CMD_INSERT, 0, 0, 1);
      send_request(CMD_GET, 63, 0, 0);
      send_request(CMD_GET, 64, 0, 0);
      send_request(CMD_SET, 0, 0, 32'h7fff_ffff);
      send_request(CMD_FIND, 0, 0, 32'h7fff_ffff);
      send_request(CMD_SWAP, 0, 63, 0);
      send_request(CMD_SWAP, 7, 7, 0);
      send_request(CMD_REVERSE, 0, 0, 0);
      send_request(CMD_DELETE, 63, 0, 0);
      send_request(CMD_DELETE, 127, 63, 32'hffff_ffff);
      send_request(CMD_CLEAR, 0, 0, 0);
      // pressure: receiver holds off while requests keep coming
      pressure_go <= 1;
      for (int k = 0; k < 20; k++)
         send_request(CMD_INSERT, 0, 0, $urandom());
      // random traffic biased to valid positions
      while (request_count < 950) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++) begin
            op = cmd_type'($urandom_range(0, 7));
            if (op == CMD_CLEAR && $urandom_range(0, 5) != 0) op = CMD_INSERT;
            if (op == CMD_INSERT && model_length > 40 && $urandom_range(0, 1)) op = CMD_DELETE;
            pos = $urandom_range(0, 9) == 0 ? 7'($urandom_range(0, 127))
                  : 7'($urandom_range(0, model_length));
            send_request(op, pos, 6'($urandom_range(0, model_length > 0 ? model_length : 0)),
                         random_value());
         end
         idle_gap();
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d list commands, checked %0d responses, incl. full/empty and long stall.",
               request_count, response_count);
      if (error_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end
endmodule

FILE: sim.f
rtl/ill_pkg.sv
rtl/ill_datapath.sv
rtl/ill_controller.sv
rtl/indexed_linked_list_engine.sv
tb/indexed_linked_list_engine_checker.sv
tb/indexed_linked_list_engine_test.sv
